// ----- rtl/disc_record_date_to_epoch_core_macros.svh -----
// Assertion macros used by the top RTL file of the timestamp converter.
`ifndef DISC_RECORD_DATE_TO_EPOCH_CORE_MACROS_SVH
`define DISC_RECORD_DATE_TO_EPOCH_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define DRDE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define DRDE_ASSERT_NEXT(lbl, clk, rstn, cond, expect_next) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expect_next)) \
        else $error("assertion failed");
`else
`define DRDE_ASSERT(lbl, clk, rstn, prop)
`define DRDE_ASSERT_NEXT(lbl, clk, rstn, cond, expect_next)
`endif

`endif

// ----- rtl/drde_pkg.sv -----
`default_nettype none

package drde_pkg;

    localparam int unsigned ACC_W  = 34;
    localparam int unsigned MUL_W  = 10;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IN_W   = 7 * BYTE_W;
    localparam int unsigned OUT_W  = 40;

    localparam logic [BYTE_W-1:0] EPOCH_YEAR_BASE = 8'd70;
    localparam logic [BYTE_W-1:0] LEAP_RUN_BASE   = 8'd69;
    localparam logic [BYTE_W-1:0] LEAP_RUN_START  = 8'd72;
    localparam logic [BYTE_W-1:0] MONTH_FEB       = 8'd2;

    localparam logic signed [BYTE_W-1:0] ZONE_LOW  = -8'sd48;
    localparam logic signed [BYTE_W-1:0] ZONE_HIGH = 8'sd52;

    localparam logic [MUL_W-1:0] K_DAYS_PER_YEAR    = MUL_W'(365);
    localparam logic [MUL_W-1:0] K_QUARTERS_PER_DAY = MUL_W'(24 * 4);
    localparam logic [MUL_W-1:0] K_QUARTER_SECONDS  = MUL_W'(60 * 15);
    localparam logic [MUL_W-1:0] K_MINUTE_SECONDS   = MUL_W'(60);

    typedef struct packed {
        logic                    load;
        logic                    m_from_acc;
        logic                    keep_acc;
        logic signed [ACC_W-1:0] m_val;
        logic signed [ACC_W-1:0] acc_val;
        logic [MUL_W-1:0]        k_val;
    } t_mac_cmd;

    // Days in the months before the given one; months above twelve count as December.
    function automatic logic [8:0] f_month_base(input logic [BYTE_W-1:0] month);
        logic [8:0] days;
        case (month) inside
            [8'd0:8'd1]: days = 9'd0;
            8'd2:        days = 9'd31;
            8'd3:        days = 9'd59;
            8'd4:        days = 9'd90;
            8'd5:        days = 9'd120;
            8'd6:        days = 9'd151;
            8'd7:        days = 9'd181;
            8'd8:        days = 9'd212;
            8'd9:        days = 9'd243;
            8'd10:       days = 9'd273;
            8'd11:       days = 9'd304;
            default:     days = 9'd334;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/drde_mac.sv -----
`default_nettype none

module drde_mac (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire drde_pkg::t_mac_cmd                    i_cmd,
    output logic signed [drde_pkg::ACC_W-1:0]          o_acc,
    output logic                                       o_done
);

    logic signed [drde_pkg::ACC_W-1:0] r_m;
    logic signed [drde_pkg::ACC_W-1:0] n_m;
    logic signed [drde_pkg::ACC_W-1:0] r_acc;
    logic signed [drde_pkg::ACC_W-1:0] n_acc;
    logic [drde_pkg::MUL_W-1:0]        r_k;
    logic [drde_pkg::MUL_W-1:0]        n_k;

    // The constant factor leaves one bit per cycle; the multiplicand doubles each step.
    always_comb begin
        n_m   = r_m;
        n_k   = r_k;
        n_acc = r_acc;
        if (i_cmd.load) begin
            n_m   = i_cmd.m_from_acc ? r_acc : i_cmd.m_val;
            n_k   = i_cmd.k_val;
            n_acc = i_cmd.keep_acc ? r_acc : i_cmd.acc_val;
        end else if (r_k != '0) begin
            if (r_k[0]) begin
                n_acc = r_acc + r_m;
            end
            n_m = {r_m[drde_pkg::ACC_W-2:0], 1'b0};
            n_k = {1'b0, r_k[drde_pkg::MUL_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else begin
            r_k <= n_k;
        end
        r_m   <= n_m;
        r_acc <= n_acc;
    end

    assign o_acc  = r_acc;
    assign o_done = (r_k == '0);

endmodule

`default_nettype wire

// ----- rtl/disc_record_date_to_epoch_core.sv -----
// Converts a seven-byte directory-record timestamp into signed seconds since 1970.
// The slave channel takes one request: year, month, day, hour, minute, second and
// the two's complement quarter-hour zone byte, packed a byte each from bit 0 up.
// The master channel returns the 34-bit signed second count in the low bits of
// m_axis_tdata. Years before 1970 give zero, and a zone byte outside -48..52 is
// ignored.
// The work runs through one shift-and-add unit that consumes a bit of a constant
// factor per cycle: days from years, quarter hours from days, seconds from quarter
// hours and from minutes, each pass opening with a load of the unit.
// A request is accepted only in the idle state, so a new one is taken only after
// the last result has been written to the output register.
// The output register lets the next request start while a result waits; if the
// receiver still stalls when the next result is done, the block holds it and
// accepts nothing until m_axis_tready frees the register.
// Reset clears the sequencer and the output valid flag; no request is in flight.
`default_nettype none

`include "disc_record_date_to_epoch_core_macros.svh"

module disc_record_date_to_epoch_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // year_since_1900, month_number, day_of_month, hour_value, minute_value,
    // second_value, zone_offset_raw
    input  wire logic [drde_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // epoch_seconds in bits 33:0, zero padding above
    output logic [drde_pkg::OUT_W-1:0]         m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_YEAR,
        S_DAY,
        S_QUARTER,
        S_MINUTE,
        S_HOLD
    } t_state;

    t_state                            r_state;
    logic                              r_out_valid;
    logic signed [drde_pkg::ACC_W-1:0] r_out;
    logic                              r_pre_epoch;
    logic signed [11:0]                r_hour_zone;
    logic [drde_pkg::BYTE_W-1:0]       r_minute;
    logic [drde_pkg::BYTE_W-1:0]       r_second;

    logic [drde_pkg::BYTE_W-1:0]       w_year;
    logic [drde_pkg::BYTE_W-1:0]       w_month;
    logic [drde_pkg::BYTE_W-1:0]       w_day;
    logic [drde_pkg::BYTE_W-1:0]       w_hour;
    logic signed [drde_pkg::BYTE_W-1:0] w_zone;
    logic [drde_pkg::BYTE_W-1:0]       w_years;
    logic [drde_pkg::BYTE_W-1:0]       w_leap_run;
    logic [5:0]                        w_leap_days;
    logic                              w_leap_now;
    logic [9:0]                        w_day_sum;
    logic                              w_zone_ok;
    logic signed [11:0]                w_hour_zone;
    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_last_pass;
    logic                              w_out_load;
    drde_pkg::t_mac_cmd                w_cmd;
    logic signed [drde_pkg::ACC_W-1:0] w_acc;
    logic                              w_done;

    assign w_year   = s_axis_tdata[7:0];
    assign w_month  = s_axis_tdata[15:8];
    assign w_day    = s_axis_tdata[23:16];
    assign w_hour   = s_axis_tdata[31:24];
    assign w_zone   = $signed(s_axis_tdata[55:48]);

    assign w_years     = w_year - drde_pkg::EPOCH_YEAR_BASE;
    assign w_leap_run  = w_year - drde_pkg::LEAP_RUN_BASE;
    assign w_leap_days = (w_year > drde_pkg::LEAP_RUN_START) ? w_leap_run[7:2] : 6'd0;
    assign w_leap_now  = (w_year[1:0] == 2'b00) && (w_month > drde_pkg::MONTH_FEB);
    assign w_day_sum   = 10'(w_leap_days) + 10'(drde_pkg::f_month_base(w_month))
                       + 10'(w_leap_now) + 10'(w_day);
    assign w_zone_ok   = (w_zone >= drde_pkg::ZONE_LOW) && (w_zone <= drde_pkg::ZONE_HIGH);
    assign w_hour_zone = $signed({2'b00, w_hour, 2'b00})
                       + (w_zone_ok ? 12'(w_zone) : 12'sd0);

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_last_pass = (r_state == S_MINUTE) || (r_state == S_HOLD);
    assign w_out_load  = w_last_pass && w_done && w_out_free;

    always_comb begin
        w_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.load    = 1'b1;
                    w_cmd.m_val   = $signed({{(drde_pkg::ACC_W-drde_pkg::BYTE_W){1'b0}}, w_years});
                    w_cmd.k_val   = drde_pkg::K_DAYS_PER_YEAR;
                    w_cmd.acc_val = $signed({{(drde_pkg::ACC_W-10){1'b0}}, w_day_sum})
                                  - drde_pkg::ACC_W'(1);
                end
            end
            S_YEAR: begin
                if (w_done) begin
                    w_cmd.load       = 1'b1;
                    w_cmd.m_from_acc = 1'b1;
                    w_cmd.k_val      = drde_pkg::K_QUARTERS_PER_DAY;
                    w_cmd.acc_val    = drde_pkg::ACC_W'(r_hour_zone);
                end
            end
            S_DAY: begin
                if (w_done) begin
                    w_cmd.load       = 1'b1;
                    w_cmd.m_from_acc = 1'b1;
                    w_cmd.k_val      = drde_pkg::K_QUARTER_SECONDS;
                    w_cmd.acc_val    = $signed({{(drde_pkg::ACC_W-drde_pkg::BYTE_W){1'b0}},
                                                r_second});
                end
            end
            S_QUARTER: begin
                if (w_done) begin
                    w_cmd.load     = 1'b1;
                    w_cmd.keep_acc = 1'b1;
                    w_cmd.m_val    = $signed({{(drde_pkg::ACC_W-drde_pkg::BYTE_W){1'b0}},
                                             r_minute});
                    w_cmd.k_val    = drde_pkg::K_MINUTE_SECONDS;
                end
            end
            S_MINUTE, S_HOLD: begin
                w_cmd = '0;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    drde_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_acc   (w_acc),
        .o_done  (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pre_epoch <= (w_year < drde_pkg::EPOCH_YEAR_BASE);
                        r_hour_zone <= w_hour_zone;
                        r_minute    <= s_axis_tdata[39:32];
                        r_second    <= s_axis_tdata[47:40];
                        r_state     <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (w_done) begin
                        r_state <= S_DAY;
                    end
                end
                S_DAY: begin
                    if (w_done) begin
                        r_state <= S_QUARTER;
                    end
                end
                S_QUARTER: begin
                    if (w_done) begin
                        r_state <= S_MINUTE;
                    end
                end
                S_MINUTE, S_HOLD: begin
                    if (w_out_load) begin
                        r_out   <= r_pre_epoch ? '0 : w_acc;
                        r_state <= S_IDLE;
                    end else if (w_done) begin
                        r_state <= S_HOLD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(drde_pkg::OUT_W-drde_pkg::ACC_W){1'b0}}, r_out};

    `DRDE_ASSERT(a_accept_unit_idle, i_clk, i_rst_n, w_accept |-> w_done)
    `DRDE_ASSERT_NEXT(a_accept_starts_year, i_clk, i_rst_n, w_accept, r_state == S_YEAR && !w_done)
    `DRDE_ASSERT(a_result_from_last_pass, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_last_pass))
    `DRDE_ASSERT_NEXT(a_hold_keeps_result, i_clk, i_rst_n, r_state == S_HOLD && !w_out_free, r_state == S_HOLD)

endmodule

`default_nettype wire

// ----- bench/disc_record_date_to_epoch_core_tb.sv -----
`default_nettype none

module disc_record_date_to_epoch_core_tb;

    localparam int  UNIX_YEAR_OFFSET = 70;
    localparam int  DAYS_IN_YEAR     = 365;
    localparam int  ZONE_MIN_QUARTER = -48;
    localparam int  ZONE_MAX_QUARTER = 52;
    localparam int  QUARTER_SECONDS  = 900;
    localparam int  IDLE_PERCENT     = 14;
    localparam int  DRAIN_CYCLES     = 80;
    localparam int  HOLD_OFF_CYCLES  = 500;
    localparam int  MONTH_LEN [12]   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [7:0] zone;
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } rec_date_t;

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // year_since_1900, month_number, day_of_month, hour_value, minute_value,
    // second_value, zone_offset_raw
    logic [drde_pkg::IN_W-1:0]    s_axis_tdata  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // epoch_seconds in bits 33:0, zero padding above
    logic [drde_pkg::OUT_W-1:0]   m_axis_tdata;

    logic [drde_pkg::OUT_W-1:0]   pending_epochs [$];
    logic [drde_pkg::OUT_W-1:0]   oldest_epoch;
    int                           mismatch_count = 0;
    int                           hold_left      = 0;
    bit                           idle_on        = 1'b1;

    disc_record_date_to_epoch_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [drde_pkg::OUT_W-1:0] epoch_of_date(input rec_date_t d);
        longint years;
        longint month;
        longint days;
        longint secs;
        longint zone;
        int     i;
        years = longint'(d.year) - UNIX_YEAR_OFFSET;
        month = longint'(d.month);
        if (years < 0) begin
            return '0;
        end
        days = years * DAYS_IN_YEAR;
        if (years > 2) begin
            days += (years + 1) / 4;
        end
        for (i = 1; i < month && i < 12; i++) begin
            days += MONTH_LEN[i - 1];
        end
        if ((years + 2) % 4 == 0 && month > 2) begin
            days++;
        end
        days += longint'(d.day) - 1;
        secs = ((days * 24 + longint'(d.hour)) * 60 + longint'(d.minute)) * 60
               + longint'(d.second);
        zone = longint'($signed(d.zone));
        if (zone >= ZONE_MIN_QUARTER && zone <= ZONE_MAX_QUARTER) begin
            secs += zone * QUARTER_SECONDS;
        end
        return {{(drde_pkg::OUT_W - drde_pkg::ACC_W){1'b0}}, secs[drde_pkg::ACC_W-1:0]};
    endfunction

    function automatic rec_date_t make_date(input int y, input int mo, input int dy,
                                            input int h, input int mi, input int s,
                                            input int z);
        rec_date_t d;
        d.year   = y[7:0];
        d.month  = mo[7:0];
        d.day    = dy[7:0];
        d.hour   = h[7:0];
        d.minute = mi[7:0];
        d.second = s[7:0];
        d.zone   = z[7:0];
        return d;
    endfunction

    function automatic rec_date_t wellformed_date();
        return make_date($urandom_range(255, UNIX_YEAR_OFFSET), $urandom_range(12, 1),
                         $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                         $urandom_range(59),
                         int'($urandom_range(ZONE_MAX_QUARTER - ZONE_MIN_QUARTER))
                         + ZONE_MIN_QUARTER);
    endfunction

    function automatic rec_date_t raw_date();
        rec_date_t   d;
        logic [63:0] raw_bits;
        raw_bits = {$urandom, $urandom};
        d = rec_date_t'(raw_bits[drde_pkg::IN_W-1:0]);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [drde_pkg::OUT_W-1:0] got,
                                   input logic [drde_pkg::OUT_W-1:0] want);
        mismatch_count++;
        $display("%0t: %s: got %h (%0d), expected %h (%0d)", $realtime, what, got,
                 $signed(got[drde_pkg::ACC_W-1:0]), want, $signed(want[drde_pkg::ACC_W-1:0]));
    endtask

    task automatic send_date(input rec_date_t d);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_epochs.push_back(epoch_of_date(d));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_epochs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_epochs.size() == 0) begin
                report_mismatch("result with no request pending", m_axis_tdata, '0);
            end else begin
                oldest_epoch = pending_epochs.pop_front();
                if (m_axis_tdata !== oldest_epoch) begin
                    report_mismatch("epoch_seconds", m_axis_tdata, oldest_epoch);
                end
            end
        end
    end

    task automatic test_directed();
        send_date(make_date(0, 0, 0, 0, 0, 0, 0));
        send_date(make_date(69, 12, 31, 23, 59, 59, 16));
        send_date(make_date(70, 1, 1, 0, 0, 0, 0));
        send_date(make_date(70, 1, 0, 0, 0, 0, 0));
        send_date(make_date(70, 1, 0, 0, 0, 0, -48));
        send_date(make_date(70, 1, 1, 0, 0, 0, -49));
        send_date(make_date(71, 12, 31, 23, 59, 59, 52));
        send_date(make_date(71, 6, 15, 12, 0, 0, 53));
        send_date(make_date(72, 2, 29, 0, 0, 0, 0));
        send_date(make_date(72, 3, 1, 0, 0, 0, 0));
        send_date(make_date(72, 0, 1, 0, 0, 0, 0));
        send_date(make_date(72, 13, 1, 0, 0, 0, 0));
        send_date(make_date(72, 255, 1, 0, 0, 0, 0));
        send_date(make_date(74, 3, 1, 0, 0, 0, 0));
        send_date(make_date(75, 1, 31, 0, 0, 0, 0));
        send_date(make_date(75, 2, 1, 0, 0, 0, 0));
        send_date(make_date(200, 3, 1, 0, 0, 0, 0));
        send_date(make_date(80, 5, 255, 1, 2, 3, 4));
        send_date(make_date(100, 7, 4, 255, 255, 255, -1));
        send_date(make_date(255, 12, 31, 23, 59, 59, 52));
        send_date(make_date(255, 255, 255, 255, 255, 255, 52));
        send_date(make_date(255, 6, 6, 6, 6, 6, 8'h80));
        send_date(make_date(255, 6, 6, 6, 6, 6, 8'h7f));
        send_date(make_date(255, 255, 255, 255, 255, 255, 255));
        wait_drain();
    endtask

    task automatic test_wellformed_random();
        repeat (900) send_date(wellformed_date());
        wait_drain();
    endtask

    task automatic test_raw_random();
        repeat (550) send_date(raw_date());
        wait_drain();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (200) begin
            if ($urandom_range(1)) begin
                send_date(wellformed_date());
            end else begin
                send_date(raw_date());
            end
        end
        wait_drain();
        idle_on = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering requests, so the
    // output register fills and the block has to stall its input.
    task automatic test_receiver_hold_off();
        idle_on   = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        repeat (20) send_date(wellformed_date());
        wait_drain();
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_wellformed_random();
        test_raw_random();
        test_no_idle();
        test_receiver_hold_off();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_epochs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/drde_pkg.sv
rtl/drde_mac.sv
rtl/disc_record_date_to_epoch_core.sv
bench/disc_record_date_to_epoch_core_tb.sv
